### src/sfrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared types and constants of the serial frame receive checker.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam int unsigned MIN_FRAME_BYTES_DEF = 7;
    localparam int unsigned BUFFER_BYTES_DEF    = 256;

    localparam logic [15:0] HEADER_RESET = 16'h55AA;

    // frame layout
    localparam int unsigned POS_HDR_HI  = 0;
    localparam int unsigned POS_HDR_LO  = 1;
    localparam int unsigned POS_VERSION = 2;
    localparam int unsigned POS_COMMAND = 3;
    localparam int unsigned POS_LEN_HI  = 4;
    localparam int unsigned POS_LEN_LO  = 5;
    localparam int unsigned HEAD_BYTES  = 6;

    // config register map
    localparam int unsigned ADDR_W     = 3;
    localparam logic        REG_HEADER = 1'b0;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LONG     = 3'd2,
        ST_HEADER   = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_version;
        logic [7:0]  frame_command;
        logic [15:0] payload_length;
        t_status     status;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### src/serial_frame_receive_checker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receive_checker_core
// Receive-side deframer and checker for idle-delimited serial bursts.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, stall apart, and parses header, version,
// command, length, payload and an 8-bit sum checksum. Each payload byte is
// passed on as an item at once; the byte that closes a burst also yields a
// verdict item, so one input item gives zero, one or two result items. Input
// items are taken at one per cycle unless stalled: the frame state is updated
// from each accepted byte and the results go into a four-entry result queue
// that drains one item per cycle unless the output stalls. The input stalls
// only while fewer than two queue entries are free, so a sustained rate of one
// byte per cycle holds whenever the output is not stalled.
module serial_frame_receive_checker_core #(
    parameter int unsigned MIN_FRAME_BYTES = sfrc_pkg::MIN_FRAME_BYTES_DEF,
    parameter int unsigned BUFFER_BYTES    = sfrc_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // byte input
    input  wire logic                        i_rx_valid,
    output logic                             o_rx_stall,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic                        i_burst_end,
    // result output
    output logic                             o_res_valid,
    input  wire logic                        i_res_stall,
    output logic                             o_kind,
    output logic [7:0]                       o_payload_byte,
    output logic [7:0]                       o_payload_index,
    output logic [7:0]                       o_frame_version,
    output logic [7:0]                       o_frame_command,
    output logic [15:0]                      o_payload_length,
    output logic [2:0]                       o_status,
    output logic                             o_last,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sfrc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import sfrc_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned CMP_W = (CNT_W > 17) ? CNT_W + 1 : 17;

    logic [15:0]      r_expected_header;

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_running_sum, n_running_sum;
    logic [15:0]      r_header_word, n_header_word;
    logic [7:0]       r_version_byte, n_version_byte;
    logic [7:0]       r_command_byte, n_command_byte;
    logic [15:0]      r_length_word, n_length_word;
    logic [7:0]       r_checksum_byte, n_checksum_byte;

    t_result          r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head, r_tail;
    logic [QCNT_W-1:0] r_count, n_count;

    logic             rx_accept, res_accept;
    logic             stored, has_payload;
    logic [CMP_W-1:0] pos_ext, csum_pos, csum_limit;
    logic [1:0]       push_num;
    t_status          verdict;
    t_result          pay_res, ver_res, push0, push1;
    t_result          head_res;

    // ---- config port
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_HEADER) ? {16'd0, r_expected_header} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_header <= HEADER_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1] == REG_HEADER) begin
            r_expected_header <= pwdata[15:0];
        end
    end

    // ---- handshakes
    assign o_rx_stall  = (r_count > QCNT_W'(QUEUE_DEPTH - 2));
    assign rx_accept   = i_rx_valid && !o_rx_stall;
    assign o_res_valid = (r_count != '0);
    assign res_accept  = o_res_valid && !i_res_stall;

    // ---- frame parsing
    assign stored     = (r_byte_count < CNT_W'(BUFFER_BYTES));
    assign pos_ext    = CMP_W'(r_byte_count);
    assign csum_pos   = CMP_W'(HEAD_BYTES) + CMP_W'(r_length_word);
    assign has_payload = stored && (pos_ext >= CMP_W'(HEAD_BYTES)) && (pos_ext < csum_pos);

    always_comb begin
        n_byte_count    = r_byte_count;
        n_running_sum   = r_running_sum;
        n_header_word   = r_header_word;
        n_version_byte  = r_version_byte;
        n_command_byte  = r_command_byte;
        n_length_word   = r_length_word;
        n_checksum_byte = r_checksum_byte;
        if (stored) begin
            case (r_byte_count)
                CNT_W'(POS_HDR_HI):  n_header_word  = {i_rx_byte, 8'd0};
                CNT_W'(POS_HDR_LO):  n_header_word  = {r_header_word[15:8], i_rx_byte};
                CNT_W'(POS_VERSION): n_version_byte = i_rx_byte;
                CNT_W'(POS_COMMAND): n_command_byte = i_rx_byte;
                CNT_W'(POS_LEN_HI):  n_length_word  = {i_rx_byte, 8'd0};
                CNT_W'(POS_LEN_LO):  n_length_word  = {r_length_word[15:8], i_rx_byte};
                default: ;
            endcase
            if (pos_ext < csum_pos) begin
                n_running_sum = r_running_sum + i_rx_byte;
            end else if (pos_ext == csum_pos) begin
                n_checksum_byte = i_rx_byte;
            end
            n_byte_count = r_byte_count + CNT_W'(1);
        end
    end

    // verdict from the updated frame state
    assign csum_limit = CMP_W'(HEAD_BYTES) + CMP_W'(n_length_word);

    always_comb begin
        if (n_byte_count < CNT_W'(MIN_FRAME_BYTES)) begin
            verdict = ST_SHORT;
        end else if (n_byte_count >= CNT_W'(BUFFER_BYTES)) begin
            verdict = ST_LONG;
        end else if (n_header_word != r_expected_header) begin
            verdict = ST_HEADER;
        end else if (csum_limit >= CMP_W'(BUFFER_BYTES)) begin
            verdict = ST_OVERFLOW;
        end else if (n_checksum_byte != n_running_sum) begin
            verdict = ST_CHECKSUM;
        end else begin
            verdict = ST_OK;
        end
    end

    always_comb begin
        pay_res                = '0;
        pay_res.kind           = KIND_PAYLOAD;
        pay_res.payload_byte   = i_rx_byte;
        pay_res.payload_index  = 8'(r_byte_count - CNT_W'(HEAD_BYTES));
        pay_res.status         = ST_OK;
        pay_res.last           = !i_burst_end;

        ver_res                = '0;
        ver_res.kind           = KIND_VERDICT;
        ver_res.frame_version  = n_version_byte;
        ver_res.frame_command  = n_command_byte;
        ver_res.payload_length = n_length_word;
        ver_res.status         = verdict;
        ver_res.last           = 1'b1;

        push0    = has_payload ? pay_res : ver_res;
        push1    = ver_res;
        push_num = rx_accept ? (2'(has_payload) + 2'(i_burst_end)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (rx_accept && i_burst_end)) begin
            r_byte_count    <= '0;
            r_running_sum   <= '0;
            r_header_word   <= '0;
            r_version_byte  <= '0;
            r_command_byte  <= '0;
            r_length_word   <= '0;
            r_checksum_byte <= '0;
        end else if (rx_accept) begin
            r_byte_count    <= n_byte_count;
            r_running_sum   <= n_running_sum;
            r_header_word   <= n_header_word;
            r_version_byte  <= n_version_byte;
            r_command_byte  <= n_command_byte;
            r_length_word   <= n_length_word;
            r_checksum_byte <= n_checksum_byte;
        end
    end

    // ---- result queue
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_queue[r_tail] <= push0;
        end
        if (push_num == 2'd2) begin
            r_queue[r_tail + QPTR_W'(1)] <= push1;
        end
    end

    assign n_count = r_count + QCNT_W'(push_num) - QCNT_W'(res_accept);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QPTR_W'(push_num);
            r_head  <= r_head + QPTR_W'(res_accept);
            r_count <= n_count;
        end
    end

    assign head_res         = r_queue[r_head];
    assign o_kind           = head_res.kind;
    assign o_payload_byte   = head_res.payload_byte;
    assign o_payload_index  = head_res.payload_index;
    assign o_frame_version  = head_res.frame_version;
    assign o_frame_command  = head_res.frame_command;
    assign o_payload_length = head_res.payload_length;
    assign o_status         = head_res.status;
    assign o_last           = head_res.last;

endmodule

`default_nettype wire

### bench/serial_frame_receive_checker_core_test.sv
// ----------------------------------------------------------------------------
// serial_frame_receive_checker_core_test
// Self-checking bench for the serial frame receive checker.
// ----------------------------------------------------------------------------
// Feeds received bytes as bursts: clean frames, frames with a broken header,
// checksum, length or end, trailing bytes and plain noise. A predictor
// parses every accepted byte and queues the payload and verdict items it
// expects; each item taken from the block is compared field by field. Both
// sides idle at random, the result side also holds off for a long stretch,
// and the frame start word is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module serial_frame_receive_checker_core_test;
    import sfrc_pkg::*;

    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_CHECKSUM,
        FLAW_TRUNCATE,
        FLAW_TRAILING,
        FLAW_OVERFLOW
    } t_flaw;

    localparam logic [ADDR_W-1:0] HEADER_ADDR = ADDR_W'(4 * int'(REG_HEADER));
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 280;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_rx_valid;
    logic                o_rx_stall;
    logic [7:0]          i_rx_byte;
    logic                i_burst_end;
    logic                o_res_valid;
    logic                i_res_stall;
    logic                o_kind;
    logic [7:0]          o_payload_byte;
    logic [7:0]          o_payload_index;
    logic [7:0]          o_frame_version;
    logic [7:0]          o_frame_command;
    logic [15:0]         o_payload_length;
    logic [2:0]          o_status;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    serial_frame_receive_checker_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .i_burst_end      (i_burst_end),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_kind           (o_kind),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_frame_version  (o_frame_version),
        .o_frame_command  (o_frame_command),
        .o_payload_length (o_payload_length),
        .o_status         (o_status),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // predictor state
    logic [15:0] cfg_header;
    int unsigned rx_count;
    logic [7:0]  rx_sum;
    logic [15:0] rx_header;
    logic [7:0]  rx_version;
    logic [7:0]  rx_command;
    logic [15:0] rx_length;
    logic [7:0]  rx_checksum;

    t_result     frame_results_due[$];
    logic [7:0]  burst_bytes[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned payload_count;
    int unsigned verdict_count[0:5];
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned hold_req;
    int unsigned hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** serial_frame_receive_checker_core: FAILED **");
        $finish;
    end

    function automatic void clear_frame();
        rx_count    = 0;
        rx_sum      = '0;
        rx_header   = '0;
        rx_version  = '0;
        rx_command  = '0;
        rx_length   = '0;
        rx_checksum = '0;
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b, logic burst_end);
        t_result     pay;
        t_result     verdict;
        logic        have_pay;
        int unsigned sum_pos;
        have_pay = 1'b0;
        pay      = '0;
        verdict  = '0;
        if (rx_count < BUFFER_BYTES_DEF) begin
            sum_pos = HEAD_BYTES + rx_length;
            case (rx_count)
                POS_HDR_HI:  rx_header[15:8] = b;
                POS_HDR_LO:  rx_header[7:0] = b;
                POS_VERSION: rx_version = b;
                POS_COMMAND: rx_command = b;
                POS_LEN_HI:  rx_length[15:8] = b;
                POS_LEN_LO:  rx_length[7:0] = b;
                default: ;
            endcase
            if (rx_count < HEAD_BYTES) begin
                rx_sum = rx_sum + b;
            end else if (rx_count < sum_pos) begin
                rx_sum            = rx_sum + b;
                have_pay          = 1'b1;
                pay.kind          = KIND_PAYLOAD;
                pay.payload_byte  = b;
                pay.payload_index = 8'(rx_count - HEAD_BYTES);
                pay.status        = ST_OK;
            end else if (rx_count == sum_pos) begin
                rx_checksum = b;
            end
            rx_count = rx_count + 1;
        end
        if (burst_end) begin
            verdict.kind           = KIND_VERDICT;
            verdict.frame_version  = rx_version;
            verdict.frame_command  = rx_command;
            verdict.payload_length = rx_length;
            if (rx_count < MIN_FRAME_BYTES_DEF)
                verdict.status = ST_SHORT;
            else if (rx_count >= BUFFER_BYTES_DEF)
                verdict.status = ST_LONG;
            else if (rx_header != cfg_header)
                verdict.status = ST_HEADER;
            else if (HEAD_BYTES + rx_length >= BUFFER_BYTES_DEF)
                verdict.status = ST_OVERFLOW;
            else if (rx_checksum != rx_sum)
                verdict.status = ST_CHECKSUM;
            else
                verdict.status = ST_OK;
            verdict.last = 1'b1;
            clear_frame();
        end else begin
            pay.last = 1'b1;
        end
        if (have_pay)
            frame_results_due.push_back(pay);
        if (burst_end)
            frame_results_due.push_back(verdict);
    endfunction

    function automatic int unsigned field_mismatch(string name, logic [15:0] want,
                                                   logic [15:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // accepted bytes
    always @(posedge i_clk) begin
        if (i_rst_n && i_rx_valid && !o_rx_stall)
            parse_rx_byte(i_rx_byte, i_burst_end);
    end

    // accepted results
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (frame_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, kind %0d status %0d", $time, o_kind,
                         o_status);
            end else begin
                want = frame_results_due.pop_front();
                errors += field_mismatch("kind", 16'(want.kind), 16'(o_kind));
                errors += field_mismatch("payload_byte", 16'(want.payload_byte),
                                         16'(o_payload_byte));
                errors += field_mismatch("payload_index", 16'(want.payload_index),
                                         16'(o_payload_index));
                errors += field_mismatch("frame_version", 16'(want.frame_version),
                                         16'(o_frame_version));
                errors += field_mismatch("frame_command", 16'(want.frame_command),
                                         16'(o_frame_command));
                errors += field_mismatch("payload_length", want.payload_length,
                                         o_payload_length);
                errors += field_mismatch("status", 16'(want.status), 16'(o_status));
                errors += field_mismatch("last", 16'(want.last), 16'(o_last));
                if (want.kind == KIND_VERDICT)
                    verdict_count[int'(want.status)]++;
                else
                    payload_count++;
            end
        end
    end

    // result side stall
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            i_res_stall <= 1'b1;
            hold_left--;
        end else begin
            i_res_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic burst_end);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_burst_end <= burst_end;
        do @(posedge i_clk); while (o_rx_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_burst();
        foreach (burst_bytes[i])
            push_byte(burst_bytes[i], i == burst_bytes.size() - 1);
    endtask

    task automatic send_frame(input int unsigned len, input t_flaw flaw,
                              input logic [7:0] ver, input logic [7:0] cmd);
        logic [15:0] hdr;
        logic [15:0] len_field;
        logic [7:0]  sum;
        int unsigned cut;
        hdr       = cfg_header;
        len_field = 16'(len);
        if (flaw == FLAW_HEADER)
            hdr = hdr ^ 16'(1 << $urandom_range(15));
        if (flaw == FLAW_OVERFLOW)
            len_field = 16'($urandom_range(65535, BUFFER_BYTES_DEF - HEAD_BYTES));
        burst_bytes.delete();
        burst_bytes.push_back(hdr[15:8]);
        burst_bytes.push_back(hdr[7:0]);
        burst_bytes.push_back(ver);
        burst_bytes.push_back(cmd);
        burst_bytes.push_back(len_field[15:8]);
        burst_bytes.push_back(len_field[7:0]);
        repeat (len) burst_bytes.push_back(8'($urandom));
        sum = '0;
        foreach (burst_bytes[i])
            sum = sum + burst_bytes[i];
        if (flaw == FLAW_CHECKSUM)
            sum = sum ^ 8'($urandom_range(255, 1));
        burst_bytes.push_back(sum);
        if (flaw == FLAW_TRUNCATE) begin
            cut = $urandom_range(burst_bytes.size() - 1, 1);
            while (burst_bytes.size() > cut)
                void'(burst_bytes.pop_back());
        end
        if (flaw == FLAW_TRAILING)
            repeat ($urandom_range(5, 1)) burst_bytes.push_back(8'($urandom));
        send_burst();
    endtask

    task automatic settle();
        i_rx_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic read_header(input logic [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= HEADER_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        errors += field_mismatch("header readback", want, prdata[15:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_header(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HEADER_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_header = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        read_header(value);
    endtask

    task automatic random_traffic(input int unsigned quota);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        start = items_sent;
        while (items_sent - start < quota) begin
            pick = $urandom_range(99);
            if ($urandom_range(19) == 0)
                len = $urandom_range(60, 17);
            else
                len = $urandom_range(16, 0);
            if (pick < 10) begin
                burst_bytes.delete();
                repeat ($urandom_range(12, 1)) burst_bytes.push_back(8'($urandom));
                send_burst();
            end else if (pick < 60) begin
                send_frame(len, FLAW_NONE, 8'($urandom), 8'($urandom));
            end else begin
                send_frame(len, t_flaw'($urandom_range(FLAW_OVERFLOW, FLAW_HEADER)),
                           8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_reset_header();
        read_header(HEADER_RESET);
    endtask

    task automatic test_directed_frames();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        burst_bytes.delete();
        burst_bytes.push_back(8'hFF);
        send_burst();
        send_frame(0, FLAW_NONE, 8'hFF, 8'h00);
        send_frame(1, FLAW_CHECKSUM, 8'h00, 8'hFF);
        send_frame(0, FLAW_HEADER, 8'h5A, 8'hA5);
        send_frame(0, FLAW_OVERFLOW, 8'hFF, 8'hFF);
        settle();
    endtask

    task automatic test_idle_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input logic [15:0] header);
        write_header(header);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        random_traffic(PHASE_ITEMS);
        settle();
    endtask

    task automatic test_buffer_limits();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_header(16'($urandom));
        // largest frame that still fits the buffer
        send_frame(BUFFER_BYTES_DEF - HEAD_BYTES - 2, FLAW_NONE, 8'($urandom), 8'($urandom));
        // fills the buffer exactly
        send_frame(BUFFER_BYTES_DEF - HEAD_BYTES - 1, FLAW_NONE, 8'($urandom), 8'($urandom));
        // runs one byte past the buffer
        send_frame(BUFFER_BYTES_DEF - HEAD_BYTES, FLAW_NONE, 8'($urandom), 8'($urandom));
        settle();
    endtask

    task automatic test_output_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req     = 200;
        send_frame(40, FLAW_NONE, 8'($urandom), 8'($urandom));
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_rx_valid    = 1'b0;
        i_rx_byte     = '0;
        i_burst_end   = 1'b0;
        i_res_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors        = 0;
        items_sent    = 0;
        payload_count = 0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        hold_req      = 0;
        hold_left     = 0;
        foreach (verdict_count[i])
            verdict_count[i] = 0;
        cfg_header = HEADER_RESET;
        clear_frame();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_header();
        test_directed_frames();
        test_idle_phase(19, 80, 16'h0000);
        test_idle_phase(80, 19, 16'hFFFF);
        test_idle_phase(0, 0, 16'($urandom));
        test_buffer_limits();
        test_output_backpressure();

        $display("run: %0d bytes in, %0d payload items, %0d verdicts, five start words",
                 items_sent, payload_count,
                 verdict_count[0] + verdict_count[1] + verdict_count[2] +
                 verdict_count[3] + verdict_count[4] + verdict_count[5]);
        $display("verdicts: ok %0d short %0d long %0d header %0d overflow %0d checksum %0d",
                 verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
                 verdict_count[4], verdict_count[5]);
        if (errors == 0) begin
            $display("** serial_frame_receive_checker_core: PASSED **");
        end else begin
            $display("** serial_frame_receive_checker_core: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
src/sfrc_pkg.sv
src/serial_frame_receive_checker_core.sv
bench/serial_frame_receive_checker_core_test.sv
